/* design/one_shot_timer_table_defines.svh */
// assertion macros for the one-shot timer table
// each use names the clock clk and the active-low reset rst_n of its module
`ifndef ONE_SHOT_TIMER_TABLE_DEFINES_SVH
`define ONE_SHOT_TIMER_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define OTT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ott: assertion failed");

// condition must never be seen out of reset
`define OTT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ott: forbidden condition seen");

`else

`define OTT_ASSERT(label, prop)
`define OTT_NEVER(label, cond)

`endif

`endif

/* design/ott_pkg.sv */
`default_nettype none

package ott_pkg;

  // stream widths, whole bytes
  localparam int IN_W  = 80;
  localparam int OUT_W = 88;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // operation codes on the input channel
  localparam logic [1:0] FN_TICK   = 2'd0;
  localparam logic [1:0] FN_CREATE = 2'd1;
  localparam logic [1:0] FN_DELETE = 2'd2;

  // status codes on the result channel
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // work kinds decided by the front
  typedef enum logic [2:0] {
    K_TICK,
    K_CREATE,
    K_DELETE,
    K_NOP,
    K_REJECT
  } kind_t;

  // back engine states
  typedef enum logic [1:0] {
    B_IDLE,
    B_TICK_SCAN,
    B_CREATE_SCAN,
    B_RESULT
  } bstate_t;

  // classified work entry
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  handler;
    logic [31:0] argument;
    logic [31:0] timeout;
    logic [3:0]  slot;
  } work_t;

  // one table entry in memory
  typedef struct packed {
    logic [7:0]  handler;
    logic [31:0] argument;
    logic [31:0] deadline;
  } entry_t;

  // result transaction fields
  typedef struct packed {
    logic [31:0] tick_now;
    logic [31:0] fired_argument;
    logic [7:0]  fired_handler;
    logic [3:0]  fired_slot;
    logic        fired;
    logic [3:0]  created_slot;
    logic [1:0]  status;
  } res_t;

endpackage

`default_nettype wire

/* design/ott_front.sv */
`default_nettype none
`include "one_shot_timer_table_defines.svh"

module ott_front
  import ott_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [IN_W-1:0] in_tdata,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output work_t                q_entry
);

  logic [1:0]  func;
  logic [7:0]  handler;
  logic [31:0] argument;
  logic [31:0] timeout;
  logic [3:0]  sel;
  work_t       work;
  logic        push;
  logic        pop;

  work_t          q_mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   cnt_r;

  // unpack the input transaction
  assign func     = in_tdata[1:0];
  assign handler  = in_tdata[9:2];
  assign argument = in_tdata[41:10];
  assign timeout  = in_tdata[73:42];
  assign sel      = in_tdata[77:74];

  // classify the request
  always_comb begin
    work.handler  = handler;
    work.argument = argument;
    work.timeout  = timeout;
    work.slot     = sel;
    case (func)
      FN_TICK: begin
        work.kind = K_TICK;
      end
      FN_CREATE: begin
        work.kind = (handler == 8'd0 || timeout == 32'd0) ? K_REJECT : K_CREATE;
      end
      FN_DELETE: begin
        work.kind = (32'(sel) < SLOTS) ? K_DELETE : K_NOP;
      end
      default: begin
        work.kind = K_REJECT;
      end
    endcase
  end

  // small queue towards the back engine
  assign in_tready = (cnt_r != (QAW+1)'(QDEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_entry   = q_mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= work;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // occupancy follows the transactions
  `OTT_ASSERT(a_q_grow, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
  `OTT_ASSERT(a_q_shrink, (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
  `OTT_NEVER(a_q_over, cnt_r > (QAW+1)'(QDEPTH))

endmodule

`default_nettype wire

/* design/ott_back.sv */
`default_nettype none
`include "one_shot_timer_table_defines.svh"

module ott_back
  import ott_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire work_t q_entry,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  bstate_t        state_r, state_nxt;
  logic [CW-1:0]  scan_idx_r, scan_idx_nxt;
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [31:0]    tick_r, tick_nxt;
  res_t           res_r, res_nxt;
  work_t          cur_r;
  logic           chk_vld_r, chk_vld_nxt;
  logic [SW-1:0]  chk_idx_r;
  logic           out_valid_r, out_valid_nxt;
  res_t           out_data_r;

  entry_t         slot_mem_r [SLOTS];
  entry_t         rd_data_r;
  entry_t         wr_data;
  logic           wr_en;
  logic [SW-1:0]  wr_addr;
  logic           rd_en;
  logic           out_load;
  logic           fire;
  logic [SW-1:0]  scan_slot;

  assign scan_slot = scan_idx_r[SW-1:0];

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem_r[scan_slot];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      tick_r      <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      tick_r      <= tick_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    res_r      <= res_nxt;
    chk_idx_r  <= scan_slot;
    if (q_valid && q_ready) begin
      cur_r <= q_entry;
    end
    if (out_load) begin
      out_data_r <= {tick_r, res_r[$bits(res_t)-33:0]};
    end
  end

  // next state and datapath control
  always_comb begin
    state_nxt        = state_r;
    scan_idx_nxt     = scan_idx_r;
    used_nxt         = used_r;
    tick_nxt         = tick_r;
    res_nxt          = res_r;
    wr_en            = 1'b0;
    wr_addr          = scan_slot;
    wr_data.handler  = cur_r.handler;
    wr_data.argument = cur_r.argument;
    wr_data.deadline = tick_r + cur_r.timeout;
    rd_en            = 1'b0;
    q_ready          = 1'b0;
    out_load         = 1'b0;
    fire             = 1'b0;
    case (state_r)
      B_IDLE: begin
        q_ready      = 1'b1;
        scan_idx_nxt = '0;
        if (q_valid) begin
          res_nxt = '0;
          case (q_entry.kind)
            K_TICK: begin
              tick_nxt  = tick_r + 32'd1;
              state_nxt = B_TICK_SCAN;
            end
            K_CREATE: begin
              state_nxt = B_CREATE_SCAN;
            end
            K_DELETE: begin
              used_nxt[SW'(q_entry.slot)] = 1'b0;
              state_nxt                   = B_RESULT;
            end
            K_REJECT: begin
              res_nxt.status = ST_INVALID;
              state_nxt      = B_RESULT;
            end
            default: begin
              state_nxt = B_RESULT;
            end
          endcase
        end
      end
      B_TICK_SCAN: begin
        // issue one read a cycle, check the entry read the cycle before
        rd_en = (scan_idx_r < CW'(SLOTS));
        if (rd_en) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (chk_vld_r && used_r[chk_idx_r] && (tick_r >= rd_data_r.deadline)) begin
          fire                   = 1'b1;
          used_nxt[chk_idx_r]    = 1'b0;
          res_nxt.fired          = 1'b1;
          res_nxt.fired_slot     = 4'(chk_idx_r);
          res_nxt.fired_handler  = rd_data_r.handler;
          res_nxt.fired_argument = rd_data_r.argument;
          state_nxt              = B_RESULT;
        end else if (chk_vld_r && chk_idx_r == LAST) begin
          state_nxt = B_RESULT;
        end
      end
      B_CREATE_SCAN: begin
        // lowest free slot wins
        if (!used_r[scan_slot]) begin
          wr_en                = 1'b1;
          used_nxt[scan_slot]  = 1'b1;
          res_nxt.created_slot = 4'(scan_slot);
          state_nxt            = B_RESULT;
        end else if (scan_slot == LAST) begin
          res_nxt.status = ST_FULL;
          state_nxt      = B_RESULT;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      B_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    chk_vld_nxt = rd_en && (state_nxt == B_TICK_SCAN);
  end

  // output register
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_data_r;

  // a create never overwrites a live timer
  `OTT_NEVER(a_wr_live, wr_en && used_r[wr_addr])
  // firing frees exactly one slot
  `OTT_ASSERT(a_fire_frees, fire |=> ($countones(used_r) == $past($countones(used_r)) - 1))
  // a popped request always starts work
  `OTT_ASSERT(a_pop_busy, (q_valid && q_ready) |=> (state_r != B_IDLE))

endmodule

`default_nettype wire

/* design/one_shot_timer_table.sv */
// one-shot timer table
// in_*  : request transactions: tick, create or delete
// out_* : one result transaction per request, in request order
// a create takes the lowest free slot with deadline = count + timeout; a tick
// bumps the 32-bit count and fires and frees the lowest expired slot, if any.
// a front stage classifies requests into a two-entry queue; a back engine
// runs them one at a time against the slot memory.
// a tick scans the slot memory one slot per cycle over its single read
// port and stops at the first slot that fires; a create scans the used
// flags one slot per cycle; a delete or rejected request goes straight
// to the result. with the engine idle, the engine takes the queue entry
// the cycle after accept.
// reset clears the count and marks every slot free; no clearing pass.
// when the receiver stalls the result is held in the output register, the
// engine finishes its next request and waits, and the queue keeps taking
// requests until it is full, then in_tready drops.
`default_nettype none

module one_shot_timer_table
  import ott_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // func[1:0], handler_id[9:2], argument[41:10], timeout[73:42], slot[77:74]
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // status[1:0], created_slot[5:2], fired[6], fired_slot[10:7],
  // fired_handler[18:11], fired_argument[50:19], tick_now[82:51]
  output logic [OUT_W-1:0]      out_tdata
);

  logic  q_valid;
  logic  q_ready;
  work_t q_entry;
  res_t  res;

  // request classification and queue
  ott_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry)
  );

  // slot table engine
  ott_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  // pack the result transaction
  assign out_tdata = {(OUT_W - $bits(res_t))'(0), res};

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ott_pkg::*;

  localparam int TBL_SLOTS   = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = TBL_SLOTS + 8;
  localparam int HOLD_AFTER  = 150;
  localparam int HOLD_LEN    = 120;

  // one request as the sender sees it
  typedef struct {
    logic [1:0]  fn;
    logic [7:0]  hid;
    logic [31:0] arg;
    logic [31:0] tmo;
    logic [3:0]  sel;
  } timer_req_t;

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata   = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // mirror of the timer table
  logic [31:0] tick_mirror;
  logic [7:0]  tbl_handler  [TBL_SLOTS];
  logic [31:0] tbl_deadline [TBL_SLOTS];
  logic [31:0] tbl_argument [TBL_SLOTS];

  timer_req_t pending_reqs[$];
  res_t       expected_results[$];

  int errors      = 0;
  int n_accepted  = 0;
  int n_results   = 0;
  int n_created   = 0;
  int n_fired     = 0;
  int n_full      = 0;
  int n_invalid   = 0;
  int total_items = 0;
  int cycles      = 0;
  logic in_taken  = 1'b0;

  one_shot_timer_table #(.SLOTS(TBL_SLOTS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // next table state and the result of one request
  function automatic res_t timer_table_step(timer_req_t q);
    res_t r;
    int   free_idx;
    r = '0;
    free_idx = -1;
    case (q.fn)
      FN_TICK: begin
        tick_mirror = tick_mirror + 32'd1;
        for (int i = 0; i < TBL_SLOTS; i++) begin
          if (!r.fired && tbl_handler[i] != 8'd0 && tick_mirror >= tbl_deadline[i]) begin
            r.fired          = 1'b1;
            r.fired_slot     = 4'(i);
            r.fired_handler  = tbl_handler[i];
            r.fired_argument = tbl_argument[i];
            tbl_handler[i]   = 8'd0;
            n_fired++;
          end
        end
      end
      FN_CREATE: begin
        if (q.hid == 8'd0 || q.tmo == 32'd0) begin
          r.status = ST_INVALID;
          n_invalid++;
        end else begin
          for (int i = TBL_SLOTS - 1; i >= 0; i--)
            if (tbl_handler[i] == 8'd0) free_idx = i;
          if (free_idx < 0) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            tbl_handler[free_idx]  = q.hid;
            tbl_argument[free_idx] = q.arg;
            tbl_deadline[free_idx] = tick_mirror + q.tmo;
            r.created_slot         = 4'(free_idx);
            n_created++;
          end
        end
      end
      FN_DELETE: begin
        if (int'(q.sel) < TBL_SLOTS) tbl_handler[q.sel] = 8'd0;
      end
      default: begin
        r.status = ST_INVALID;
        n_invalid++;
      end
    endcase
    r.tick_now = tick_mirror;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic queue_req(logic [1:0] fn, logic [7:0] hid, logic [31:0] arg,
                           logic [31:0] tmo, logic [3:0] sel);
    timer_req_t q;
    q.fn  = fn;
    q.hid = hid;
    q.arg = arg;
    q.tmo = tmo;
    q.sel = sel;
    pending_reqs.push_back(q);
  endtask

  // random request, mostly well-formed with short timeouts so timers fire
  function automatic timer_req_t random_req();
    timer_req_t q;
    int         pick;
    int         tsel;
    q.fn  = FN_TICK;
    q.hid = 8'($urandom_range(1, 255));
    q.arg = $urandom;
    q.sel = 4'($urandom_range(0, 15));
    tsel  = $urandom_range(0, 99);
    if (tsel < 70)      q.tmo = $urandom_range(1, 24);
    else if (tsel < 85) q.tmo = $urandom;
    else                q.tmo = 32'hFFFF_FFFF - $urandom_range(0, 300);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      q.fn = FN_TICK;
    end else if (pick < 80) begin
      q.fn = FN_CREATE;
    end else if (pick < 93) begin
      q.fn = FN_DELETE;
    end else if (pick < 96) begin
      q.fn = 2'd3;
    end else begin
      // broken create: no handler or no timeout
      q.fn = FN_CREATE;
      if ($urandom_range(0, 1)) q.hid = 8'd0;
      else q.tmo = 32'd0;
    end
    return q;
  endfunction

  // sampling: check results and predict on each input transaction
  always @(posedge clk) begin
    res_t got;
    res_t want;
    timer_req_t q;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
    in_taken <= rst_n && in_tvalid && in_tready;
    if (!rst_n) begin
      tick_mirror <= 32'd0;
      for (int i = 0; i < TBL_SLOTS; i++) begin
        tbl_handler[i]  <= 8'd0;
        tbl_deadline[i] <= 32'd0;
        tbl_argument[i] <= 32'd0;
      end
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        got = res_t'(out_tdata[$bits(res_t)-1:0]);
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t ns: result with nothing expected, actual %h", $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("status",         32'(want.status),       32'(got.status));
          check_field("created_slot",   32'(want.created_slot), 32'(got.created_slot));
          check_field("fired",          32'(want.fired),        32'(got.fired));
          check_field("fired_slot",     32'(want.fired_slot),   32'(got.fired_slot));
          check_field("fired_handler",  32'(want.fired_handler), 32'(got.fired_handler));
          check_field("fired_argument", want.fired_argument,    got.fired_argument);
          check_field("tick_now",       want.tick_now,          got.tick_now);
        end
      end
      if (in_tvalid && in_tready) begin
        n_accepted++;
        q.fn  = in_tdata[1:0];
        q.hid = in_tdata[9:2];
        q.arg = in_tdata[41:10];
        q.tmo = in_tdata[73:42];
        q.sel = in_tdata[77:74];
        expected_results.push_back(timer_table_step(q));
      end
    end
  end

  // sender: bursts of random length with random gaps
  always @(negedge clk) begin
    int         burst_left;
    int         gap_left;
    timer_req_t q;
    logic       nxt_valid;
    if (!rst_n) begin
      burst_left = $urandom_range(1, 12);
      gap_left   = 0;
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        q = pending_reqs.pop_front();
        nxt_valid = 1'b1;
        in_tdata <= {2'b00, q.sel, q.tmo, q.arg, q.hid, q.fn};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // receiver: stall pattern that changes mode, plus one long hold-off
  always @(negedge clk) begin
    int   rx_phase;
    int   rx_mode;
    int   hold_left;
    logic hold_done;
    if (!rst_n) begin
      rx_phase  = 0;
      rx_mode   = 0;
      hold_left = 0;
      hold_done = 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!hold_done && n_results >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      rx_phase++;
      if (rx_phase % 24 == 0) rx_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // stimulus and end of run
  initial begin
    // directed: rejects, unused code, wrap of a deadline, full table
    queue_req(FN_TICK,   8'h00, 32'h0,         32'h0,         4'h0);
    queue_req(2'd3,      8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    queue_req(FN_CREATE, 8'h00, 32'h1234_5678, 32'd5,         4'h0);
    queue_req(FN_CREATE, 8'h07, 32'h0,         32'd0,         4'h0);
    queue_req(FN_CREATE, 8'h00, 32'h0,         32'd0,         4'h0);
    queue_req(FN_CREATE, 8'hFF, 32'hFFFF_FFFF, 32'd1,         4'h0);
    queue_req(FN_TICK,   8'h00, 32'h0,         32'h0,         4'h0);
    queue_req(FN_DELETE, 8'h00, 32'h0,         32'h0,         4'h3);
    queue_req(FN_CREATE, 8'h01, 32'h0,         32'hFFFF_FFFF, 4'h0);
    queue_req(FN_TICK,   8'h00, 32'h0,         32'h0,         4'h0);
    for (int i = 0; i < TBL_SLOTS; i++)
      queue_req(FN_CREATE, 8'(8'h80 + i), $urandom, 32'(20 + 3 * i), 4'h0);
    queue_req(FN_CREATE, 8'h55, 32'hA5A5_A5A5, 32'd9, 4'h0);
    queue_req(FN_DELETE, 8'h00, 32'h0, 32'h0, 4'hF);
    queue_req(FN_DELETE, 8'h00, 32'h0, 32'h0, 4'h0);
    for (int i = 0; i < 400; i++) pending_reqs.push_back(random_req());
    total_items = pending_reqs.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < total_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d requests, %0d results: %0d timers created, %0d fired,",
             n_accepted, n_results, n_created, n_fired);
    $display("%0d creates refused on a full table, %0d invalid requests, %0d mismatches",
             n_full, n_invalid, errors);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/ott_pkg.sv
design/ott_front.sv
design/ott_back.sv
design/one_shot_timer_table.sv
dv/testbench.sv
